>>> sv/rc_channel_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// rc channel frame decoder - assertion macros
// shared concurrent check forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_FRAME_DECODER_DEFINES_SVH
`define RC_CHANNEL_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define RCFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// types and constants of the rc channel frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  localparam int PAYLOAD_BYTES = 22;
  localparam int NUM_CHANNELS  = 16;
  localparam int CH_W          = 11;
  localparam int DZ_W          = 10;
  localparam int STICK_W       = 12;
  localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [7:0] ADDR_FC        = 8'hC8;
  localparam logic [7:0] ADDR_BCAST     = 8'h00;
  localparam logic [7:0] FRAME_SIZE     = 8'(PAYLOAD_BYTES + 2);
  localparam logic [7:0] TYPE_RC_PACKED = 8'h16;

  localparam logic [CH_W-1:0] BTN_ON   = 11'd1500;
  localparam logic [CH_W-1:0] SW_LOW   = 11'd400;
  localparam logic [CH_W-1:0] SW3_LOW  = 11'd191;
  localparam logic [CH_W-1:0] SW3_HIGH = 11'd1792;

  localparam logic [CH_W-1:0] CH_MIN_RST = 11'd172;
  localparam logic [CH_W-1:0] CH_MAX_RST = 11'd1811;
  localparam logic [CH_W-1:0] CH_MID_RST = 11'd992;
  localparam logic [DZ_W-1:0] DZ_RST     = 10'd41;

  typedef enum logic [1:0] {
    CFG_CHANNEL_MIN = 2'd0,
    CFG_CHANNEL_MAX = 2'd1,
    CFG_CHANNEL_MID = 2'd2,
    CFG_DEADZONE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_ADDR    = 5'b00001,
    PH_SIZE    = 5'b00010,
    PH_TYPE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0] ch_min;
    logic [CH_W-1:0] ch_max;
    logic [CH_W-1:0] ch_mid;
    logic [DZ_W-1:0] deadzone;
  } cfg_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] right_x;
    logic signed [STICK_W-1:0] right_y;
    logic signed [STICK_W-1:0] left_y;
    logic signed [STICK_W-1:0] left_x;
    logic                      switch_a;
    logic [1:0]                switch_b;
    logic [1:0]                switch_c;
    logic                      switch_d;
    logic                      click;
    logic [5:0]                buttons;
    logic                      emergency_edge;
  } res_t;

endpackage

`default_nettype wire

>>> sv/rcfd_parser.sv
// ----------------------------------------------------------------------------
// rcfd_parser
// frame hunt state machine and payload byte store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_channel_frame_decoder_defines.svh"

module rcfd_parser
  import rcfd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    byte_fire,
  input  wire logic [7:0]              rx_byte,
  output logic                         at_check,
  output logic [PAYLOAD_BITS-1:0]      store_flat
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [7:0]         store_r [PAYLOAD_BYTES];
  logic               store_we;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    store_we  = 1'b0;
    if (byte_fire) begin
      unique case (phase_r)
        PH_ADDR: begin
          if (rx_byte == ADDR_FC || rx_byte == ADDR_BCAST) begin
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          phase_nxt = (rx_byte == FRAME_SIZE) ? PH_TYPE : PH_ADDR;
        end
        PH_TYPE: begin
          if (rx_byte == TYPE_RC_PACKED) begin
            count_nxt = '0;
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_ADDR;
          end
        end
        PH_PAYLOAD: begin
          if (count_r < CNT_W'(PAYLOAD_BYTES)) begin
            store_we  = 1'b1;
            count_nxt = count_r + 1'b1;
            if (count_nxt == CNT_W'(PAYLOAD_BYTES)) begin
              phase_nxt = PH_CHECK;
            end
          end else begin
            phase_nxt = PH_ADDR;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_ADDR;
        end
        default: begin
          phase_nxt = PH_ADDR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r] <= rx_byte;
    end
  end

  for (genvar g = 0; g < PAYLOAD_BYTES; g++) begin : g_flat
    assign store_flat[g*8 +: 8] = store_r[g];
  end

  assign at_check = (phase_r == PH_CHECK);

  `RCFD_ASSERT_NOW(a_count_range, phase_r == PH_PAYLOAD,
                   count_r < CNT_W'(PAYLOAD_BYTES), "payload count past store")
  `RCFD_ASSERT_NEXT(a_check_ends, byte_fire && phase_r == PH_CHECK,
                    phase_r == PH_ADDR, "hunt not restarted after check byte")

endmodule

`default_nettype wire

>>> sv/rcfd_unpack.sv
// ----------------------------------------------------------------------------
// rcfd_unpack
// channel unpacking, range substitution, stick offsets and switch decoding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcfd_unpack
  import rcfd_pkg::*;
(
  input  wire logic [PAYLOAD_BITS-1:0] store_flat,
  input  wire cfg_t                    cfg,
  input  wire logic                    last_stop,
  output res_t                         res,
  output logic                         stop
);

  logic [CH_W-1:0] ch [NUM_CHANNELS];

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
    logic [CH_W-1:0] raw;
    assign raw   = store_flat[g*CH_W +: CH_W];
    assign ch[g] = (raw < cfg.ch_min || raw > cfg.ch_max) ? cfg.ch_mid : raw;
  end

  function automatic logic signed [STICK_W-1:0] stick(input logic [CH_W-1:0] v,
                                                      input logic [CH_W-1:0] mid,
                                                      input logic [DZ_W-1:0] dz);
    logic signed [STICK_W-1:0] off;
    logic        [STICK_W-1:0] mag;
    off = $signed({1'b0, v}) - $signed({1'b0, mid});
    mag = off[STICK_W-1] ? STICK_W'(-off) : STICK_W'(off);
    return (mag < {{(STICK_W-DZ_W){1'b0}}, dz}) ? '0 : off;
  endfunction

  function automatic logic [1:0] three_way(input logic [CH_W-1:0] v);
    if (v <= SW3_LOW) begin
      return 2'd0;
    end
    return (v >= SW3_HIGH) ? 2'd2 : 2'd1;
  endfunction

  always_comb begin
    res.right_x  = stick(ch[0], cfg.ch_mid, cfg.deadzone);
    res.right_y  = stick(ch[1], cfg.ch_mid, cfg.deadzone);
    res.left_y   = stick(ch[2], cfg.ch_mid, cfg.deadzone);
    res.left_x   = stick(ch[3], cfg.ch_mid, cfg.deadzone);
    res.switch_a = (ch[4] > BTN_ON);
    res.switch_b = three_way(ch[5]);
    res.switch_c = three_way(ch[6]);
    res.switch_d = (ch[7] >= SW_LOW);
    res.click    = (ch[8] >= SW_LOW);
    for (int k = 0; k < 6; k++) begin
      res.buttons[k] = (ch[9 + k] > BTN_ON);
    end
    stop               = (ch[10] > BTN_ON);
    res.emergency_edge = stop && !last_stop;
  end

endmodule

`default_nettype wire

>>> sv/rc_channel_frame_decoder.sv
// result valid in the cycle after the transfer of the byte that follows the payload
// throughput: one byte per cycle; in_ready drops only when that closing byte meets
//   a result still waiting with out_ready low
// reset clears the hunt phase, payload count, result valid, stop-button history
//   and loads the register defaults; the payload store is not cleared
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder
// hunts packed rc-channels frames in a byte stream and decodes sticks and switches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_channel_frame_decoder_defines.svh"

module rc_channel_frame_decoder
  import rcfd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [CH_W-1:0]           cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_rx_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [STICK_W-1:0]      out_right_x,
  output logic signed [STICK_W-1:0]      out_right_y,
  output logic signed [STICK_W-1:0]      out_left_y,
  output logic signed [STICK_W-1:0]      out_left_x,
  output logic                           out_switch_a,
  output logic [1:0]                     out_switch_b,
  output logic [1:0]                     out_switch_c,
  output logic                           out_switch_d,
  output logic                           out_click,
  output logic [5:0]                     out_buttons,
  output logic                           out_emergency_edge
);

  cfg_t                   cfg_r;
  logic                   in_fire;
  logic                   at_check;
  logic                   res_load;
  logic [PAYLOAD_BITS-1:0] store_flat;
  res_t                   res_nxt, res_r;
  logic                   stop;
  logic                   last_stop_r;
  logic                   out_valid_r, out_valid_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ch_min   <= CH_MIN_RST;
      cfg_r.ch_max   <= CH_MAX_RST;
      cfg_r.ch_mid   <= CH_MID_RST;
      cfg_r.deadzone <= DZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHANNEL_MIN: cfg_r.ch_min   <= cfg_wdata;
        CFG_CHANNEL_MAX: cfg_r.ch_max   <= cfg_wdata;
        CFG_CHANNEL_MID: cfg_r.ch_mid   <= cfg_wdata;
        CFG_DEADZONE:    cfg_r.deadzone <= cfg_wdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !at_check || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign res_load = in_fire && at_check;

  rcfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (in_fire),
    .rx_byte    (in_rx_byte),
    .at_check   (at_check),
    .store_flat (store_flat)
  );

  rcfd_unpack u_unpack (
    .store_flat (store_flat),
    .cfg        (cfg_r),
    .last_stop  (last_stop_r),
    .res        (res_nxt),
    .stop       (stop)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_stop_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (res_load) begin
        last_stop_r <= stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_right_x        = res_r.right_x;
  assign out_right_y        = res_r.right_y;
  assign out_left_y         = res_r.left_y;
  assign out_left_x         = res_r.left_x;
  assign out_switch_a       = res_r.switch_a;
  assign out_switch_b       = res_r.switch_b;
  assign out_switch_c       = res_r.switch_c;
  assign out_switch_d       = res_r.switch_d;
  assign out_click          = res_r.click;
  assign out_buttons        = res_r.buttons;
  assign out_emergency_edge = res_r.emergency_edge;

  `RCFD_ASSERT_NEXT(a_res_follows, res_load, out_valid, "no result after closing byte")
  `RCFD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid_r && !out_ready && at_check,
                   "input stalled without a waiting result")
  `RCFD_ASSERT_NOW(a_edge_button, out_valid && out_emergency_edge, out_buttons[1],
                   "emergency edge without stop button")
  `RCFD_ASSERT_NEXT(a_stop_track, res_load, last_stop_r == out_buttons[1],
                    "stop history out of step with result")

endmodule

`default_nettype wire

>>> test/rcfd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_frame_checker
// watches the byte, result and register ports of the rc channel frame decoder,
// keeps its own frame parser and channel decoder, and compares every result
// transfer field by field with the oldest predicted result
// ----------------------------------------------------------------------------

module rcfd_frame_checker
  import rcfd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CH_W-1:0]           cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [STICK_W-1:0] out_right_x,
  input  logic signed [STICK_W-1:0] out_right_y,
  input  logic signed [STICK_W-1:0] out_left_y,
  input  logic signed [STICK_W-1:0] out_left_x,
  input  logic                      out_switch_a,
  input  logic [1:0]                out_switch_b,
  input  logic [1:0]                out_switch_c,
  input  logic                      out_switch_d,
  input  logic                      out_click,
  input  logic [5:0]                out_buttons,
  input  logic                      out_emergency_edge,
  output int unsigned               mismatches,
  output int unsigned               outstanding,
  output int unsigned               results_checked
);

  cfg_t             cfg_now;
  phase_t           hunt_phase;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       frame_bytes [PAYLOAD_BYTES];
  logic             last_stop;
  res_t             predicted_results [$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  function automatic logic signed [STICK_W-1:0] stick_offset(input logic [CH_W-1:0] ch);
    int off;
    int mag;
    off = int'(ch) - int'(cfg_now.ch_mid);
    mag = (off < 0) ? -off : off;
    if (mag < int'(cfg_now.deadzone)) off = 0;
    return STICK_W'(off);
  endfunction

  function automatic logic [1:0] three_way(input logic [CH_W-1:0] ch);
    if (ch <= SW3_LOW) return 2'd0;
    return (ch >= SW3_HIGH) ? 2'd2 : 2'd1;
  endfunction

  function automatic res_t decode_frame();
    logic [PAYLOAD_BITS-1:0] bits;
    logic [CH_W-1:0]         ch [NUM_CHANNELS];
    logic [CH_W-1:0]         raw;
    res_t                    r;
    for (int b = 0; b < PAYLOAD_BYTES; b++) bits[b*8 +: 8] = frame_bytes[b];
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      raw   = bits[i*CH_W +: CH_W];
      ch[i] = (raw < cfg_now.ch_min || raw > cfg_now.ch_max) ? cfg_now.ch_mid : raw;
    end
    r.right_x  = stick_offset(ch[0]);
    r.right_y  = stick_offset(ch[1]);
    r.left_y   = stick_offset(ch[2]);
    r.left_x   = stick_offset(ch[3]);
    r.switch_a = ch[4] > BTN_ON;
    r.switch_b = three_way(ch[5]);
    r.switch_c = three_way(ch[6]);
    r.switch_d = ch[7] >= SW_LOW;
    r.click    = ch[8] >= SW_LOW;
    for (int k = 0; k < 6; k++) r.buttons[k] = ch[9+k] > BTN_ON;
    // channel 10 is button bit 1
    r.emergency_edge = r.buttons[1] && !last_stop;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    res_t r;
    case (hunt_phase)
      PH_ADDR: begin
        if (b == ADDR_FC || b == ADDR_BCAST) hunt_phase = PH_SIZE;
      end
      PH_SIZE: begin
        hunt_phase = (b == FRAME_SIZE) ? PH_TYPE : PH_ADDR;
      end
      PH_TYPE: begin
        if (b == TYPE_RC_PACKED) begin
          byte_count = '0;
          hunt_phase = PH_PAYLOAD;
        end else begin
          hunt_phase = PH_ADDR;
        end
      end
      PH_PAYLOAD: begin
        if (byte_count < PAYLOAD_BYTES) begin
          frame_bytes[byte_count] = b;
          byte_count = byte_count + 1'b1;
          if (byte_count >= PAYLOAD_BYTES) hunt_phase = PH_CHECK;
        end else begin
          hunt_phase = PH_ADDR;
        end
      end
      PH_CHECK: begin
        hunt_phase = PH_ADDR;
        r = decode_frame();
        last_stop = r.buttons[1];
        predicted_results.push_back(r);
      end
      default: hunt_phase = PH_ADDR;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      cfg_now    = '{ch_min: CH_MIN_RST, ch_max: CH_MAX_RST, ch_mid: CH_MID_RST,
                     deadzone: DZ_RST};
      hunt_phase = PH_ADDR;
      byte_count = '0;
      last_stop  = 1'b0;
      predicted_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer expected none actual right_x %0d buttons %0d",
                   $time, out_right_x, out_buttons);
        end else begin
          want = predicted_results.pop_front();
          results_checked++;
          check_field("right_x", $signed(want.right_x), out_right_x);
          check_field("right_y", $signed(want.right_y), out_right_y);
          check_field("left_y", $signed(want.left_y), out_left_y);
          check_field("left_x", $signed(want.left_x), out_left_x);
          check_field("switch_a", want.switch_a, out_switch_a);
          check_field("switch_b", want.switch_b, out_switch_b);
          check_field("switch_c", want.switch_c, out_switch_c);
          check_field("switch_d", want.switch_d, out_switch_d);
          check_field("click", want.click, out_click);
          check_field("buttons", want.buttons, out_buttons);
          check_field("emergency_edge", want.emergency_edge, out_emergency_edge);
        end
      end
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CHANNEL_MIN: cfg_now.ch_min   = cfg_wdata;
          CFG_CHANNEL_MAX: cfg_now.ch_max   = cfg_wdata;
          CFG_CHANNEL_MID: cfg_now.ch_mid   = cfg_wdata;
          CFG_DEADZONE:    cfg_now.deadzone = cfg_wdata[DZ_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

>>> test/rc_channel_frame_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder_test
// drives byte streams of packed rc-channels frames, broken headers and noise
// into the decoder under several register settings, with random stalls on
// both channels; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------

module rc_channel_frame_decoder_test;
  import rcfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          NUM_SETTINGS  = 8;
  localparam int          EVENTS_EACH   = 7;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CH_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic signed [STICK_W-1:0] out_right_x;
  logic signed [STICK_W-1:0] out_right_y;
  logic signed [STICK_W-1:0] out_left_y;
  logic signed [STICK_W-1:0] out_left_x;
  logic out_switch_a;
  logic [1:0] out_switch_b;
  logic [1:0] out_switch_c;
  logic out_switch_d;
  logic out_click;
  logic [5:0] out_buttons;
  logic out_emergency_edge;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned results_checked;

  bit          calm;
  int unsigned cycles;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned settings_used;

  logic [CH_W-1:0] cur_min;
  logic [CH_W-1:0] cur_max;
  logic [CH_W-1:0] cur_mid;
  logic [DZ_W-1:0] cur_dz;
  logic [CH_W-1:0] chan [NUM_CHANNELS];

  rc_channel_frame_decoder i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_right_x        (out_right_x),
    .out_right_y        (out_right_y),
    .out_left_y         (out_left_y),
    .out_left_x         (out_left_x),
    .out_switch_a       (out_switch_a),
    .out_switch_b       (out_switch_b),
    .out_switch_c       (out_switch_c),
    .out_switch_d       (out_switch_d),
    .out_click          (out_click),
    .out_buttons        (out_buttons),
    .out_emergency_edge (out_emergency_edge)
  );

  rcfd_frame_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_right_x        (out_right_x),
    .out_right_y        (out_right_y),
    .out_left_y         (out_left_y),
    .out_left_x         (out_left_x),
    .out_switch_a       (out_switch_a),
    .out_switch_b       (out_switch_b),
    .out_switch_c       (out_switch_c),
    .out_switch_d       (out_switch_d),
    .out_click          (out_click),
    .out_buttons        (out_buttons),
    .out_emergency_edge (out_emergency_edge),
    .mismatches         (fail_count),
    .outstanding        (pending_results),
    .results_checked    (results_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 22);

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] check);
    logic [PAYLOAD_BITS-1:0] bits;
    for (int i = 0; i < NUM_CHANNELS; i++) bits[i*CH_W +: CH_W] = chan[i];
    send_byte(addr);
    send_byte(FRAME_SIZE);
    send_byte(TYPE_RC_PACKED);
    for (int k = 0; k < PAYLOAD_BYTES; k++) send_byte(bits[k*8 +: 8]);
    send_byte(check);
    frames_sent++;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(0, 99) < 30) return CH_W'($urandom_range(0, 2047));
    case ($urandom_range(0, 17))
      0:  return '0;
      1:  return '1;
      2:  return cur_min;
      3:  return cur_min - 1'b1;
      4:  return cur_max;
      5:  return cur_max + 1'b1;
      6:  return cur_mid;
      7:  return cur_mid + CH_W'(cur_dz);
      8:  return cur_mid - CH_W'(cur_dz);
      9:  return cur_mid + CH_W'(cur_dz) - 1'b1;
      10: return BTN_ON;
      11: return BTN_ON + 1'b1;
      12: return SW3_LOW;
      13: return SW3_LOW + 1'b1;
      14: return SW3_HIGH;
      15: return SW3_HIGH - 1'b1;
      16: return SW_LOW;
      default: return SW_LOW - 1'b1;
    endcase
  endfunction

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CH_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // called at a falling edge with the block idle
  task automatic apply_config(input logic [CH_W-1:0] lo, input logic [CH_W-1:0] hi,
                              input logic [CH_W-1:0] mid, input logic [CH_W-1:0] dz);
    write_reg(CFG_CHANNEL_MIN, lo);
    write_reg(CFG_CHANNEL_MAX, hi);
    write_reg(CFG_CHANNEL_MID, mid);
    write_reg(CFG_DEADZONE, dz);
    cfg_we  <= 1'b0;
    cur_min = lo;
    cur_max = hi;
    cur_mid = mid;
    cur_dz  = dz[DZ_W-1:0];
    settings_used++;
  endtask

  task automatic random_event();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      for (int i = 0; i < NUM_CHANNELS; i++) chan[i] = pick_channel();
      send_frame($urandom_range(0, 1) ? ADDR_FC : ADDR_BCAST, 8'($urandom));
    end else if (pick < 86) begin
      // header broken at the size or the type byte
      send_byte($urandom_range(0, 1) ? ADDR_FC : ADDR_BCAST);
      if ($urandom_range(0, 1)) begin
        send_byte(FRAME_SIZE ^ 8'($urandom_range(1, 255)));
      end else begin
        send_byte(FRAME_SIZE);
        send_byte(TYPE_RC_PACKED ^ 8'($urandom_range(1, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] hi;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_CHANNEL_MIN;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    out_ready   = 1'b0;
    calm        = 1'b0;
    cycles      = 0;
    bytes_sent  = 0;
    frames_sent = 0;
    settings_used = 1;
    cur_min = CH_MIN_RST;
    cur_max = CH_MAX_RST;
    cur_mid = CH_MID_RST;
    cur_dz  = DZ_RST;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // every channel below range, then above range
    for (int i = 0; i < NUM_CHANNELS; i++) chan[i] = '0;
    send_frame(ADDR_FC, 8'h00);
    for (int i = 0; i < NUM_CHANNELS; i++) chan[i] = '1;
    send_frame(ADDR_BCAST, 8'hFF);
    // range limits, deadzone edges and switch thresholds
    chan[0]  = CH_MIN_RST;
    chan[1]  = CH_MAX_RST;
    chan[2]  = CH_MID_RST + CH_W'(DZ_RST);
    chan[3]  = CH_MID_RST - CH_W'(DZ_RST) + 1'b1;
    chan[4]  = BTN_ON + 1'b1;
    chan[5]  = SW3_LOW;
    chan[6]  = SW3_HIGH;
    chan[7]  = SW_LOW - 1'b1;
    chan[8]  = SW_LOW;
    chan[9]  = BTN_ON + 1'b1;
    chan[10] = BTN_ON;
    chan[11] = BTN_ON + 1'b1;
    chan[12] = BTN_ON + 1'b1;
    chan[13] = BTN_ON + 1'b1;
    chan[14] = BTN_ON + 1'b1;
    chan[15] = CH_MAX_RST;
    send_frame(ADDR_FC, 8'hA5);
    // stop button rises, then stays
    chan[5]  = SW3_LOW + 1'b1;
    chan[6]  = SW3_HIGH - 1'b1;
    chan[10] = BTN_ON + 1'b1;
    send_frame(ADDR_BCAST, 8'h5A);
    send_frame(ADDR_FC, 8'h3C);
    // wrong size that is itself an address byte, then wrong type, then noise
    send_byte(ADDR_FC);
    send_byte(ADDR_FC);
    send_byte(ADDR_BCAST);
    send_byte(FRAME_SIZE);
    send_byte(8'h17);
    send_byte(8'h42);
    chan[10] = SW_LOW;
    send_frame(ADDR_FC, 8'hC3);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      settle();
      calm = (s == 1);
      case (s)
        0: apply_config(CH_MIN_RST, CH_MAX_RST, CH_MID_RST, CH_W'(DZ_RST));
        1: apply_config('0, '1, 11'd1024, '0);
        2: apply_config('1, '0, '1, 11'd1023);
        3: apply_config('0, '0, '0, 11'd1023);
        7: apply_config(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        default: begin
          lo = CH_W'($urandom_range(0, 600));
          hi = CH_W'($urandom_range(1200, 2047));
          apply_config(lo, hi, CH_W'($urandom_range(lo, hi)), CH_W'($urandom_range(0, 200)));
        end
      endcase
      repeat (EVENTS_EACH) random_event();
    end
    calm = 1'b0;
    settle();

    $display("sent %0d bytes, %0d well-formed frames, under %0d register settings",
             bytes_sent, frames_sent, settings_used);
    $display("compared %0d decoded results, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
